### hw/rtl/irdp_rx_pkg.sv
// Types, constants and helper functions shared by the IRDP receive check modules.
package irdp_rx_pkg;

  localparam int LINK_AND_IP_SLACK = 34;
  localparam logic [15:0] MIN_ICMP_BYTES = 16'd8;
  localparam logic [7:0] TYPE_ADVERT = 8'd9;
  localparam logic [7:0] TYPE_SOLICIT = 8'd10;
  localparam logic [31:0] ADDR_BROADCAST = 32'hFFFF_FFFF;
  localparam logic [31:0] ADDR_ALL_ROUTERS = 32'hE000_0002;

  localparam logic [0:0] CFG_INTERFACE_ENABLED = 1'b0;
  localparam logic [0:0] CFG_BROADCAST_MODE = 1'b1;

  typedef enum logic [3:0] {
    VERDICT_ADVERT       = 4'd0,
    VERDICT_SOLICIT      = 4'd1,
    VERDICT_LEN_MISMATCH = 4'd2,
    VERDICT_SHORT        = 4'd3,
    VERDICT_LONG         = 4'd4,
    VERDICT_CHECKSUM     = 4'd5,
    VERDICT_NOT_IRDP     = 4'd6,
    VERDICT_CODE         = 4'd7,
    VERDICT_DEST         = 4'd8,
    VERDICT_DISABLED     = 4'd9
  } verdict_t;

  typedef struct packed {
    logic [15:0] rx_len;
    logic [15:0] total_length;
    logic [15:0] sum;
    logic [7:0]  pending;
    logic        pad;
    logic [7:0]  message_type;
    logic [7:0]  message_code;
    logic [15:0] received_checksum;
    logic [31:0] destination;
    logic [31:0] source;
  } snap_t;

  function automatic logic [15:0] add_ones(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return 16'(s[15:0] + {15'b0, s[16]});
  endfunction

endpackage

### hw/rtl/irdp_rx_parse.sv
// Input register and per-packet header capture with running ones-complement sum.
module irdp_rx_parse
  import irdp_rx_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = 1500
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       snap_valid,
  input  logic       snap_ready,
  output snap_t      snap
);

  localparam logic [15:0] BUF_BYTES = 16'(RX_BUFFER_BYTES);

  logic        in_full;
  logic [7:0]  in_data;
  logic        in_end;
  logic        take;

  logic [15:0] byte_count;
  logic [5:0]  header_length;
  logic [15:0] total_length;
  logic [31:0] source_register;
  logic [31:0] destination_register;
  logic [15:0] sum_accumulator;
  logic [7:0]  pending_high_byte;
  logic [7:0]  message_type;
  logic [7:0]  message_code;
  logic [15:0] received_checksum;

  logic [15:0] byte_count_next;
  logic [5:0]  header_length_next;
  logic [15:0] total_length_next;
  logic [31:0] source_register_next;
  logic [31:0] destination_register_next;
  logic [15:0] sum_accumulator_next;
  logic [7:0]  pending_high_byte_next;
  logic [7:0]  message_type_next;
  logic [7:0]  message_code_next;
  logic [15:0] received_checksum_next;

  logic        in_buf;
  logic        in_icmp;
  logic [15:0] k;
  logic        k_small;
  logic [7:0]  v;
  logic [15:0] rx_len;

  assign take = in_full && (!in_end || !snap_valid || snap_ready);
  assign in_ready = !in_full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data <= in_byte;
      in_end <= in_last;
    end
  end

  always_comb begin
    header_length_next = header_length;
    total_length_next = total_length;
    source_register_next = source_register;
    destination_register_next = destination_register;
    sum_accumulator_next = sum_accumulator;
    pending_high_byte_next = pending_high_byte;
    message_type_next = message_type;
    message_code_next = message_code;
    received_checksum_next = received_checksum;
    v = in_data;

    in_buf = byte_count < BUF_BYTES;
    if (in_buf) begin
      if (byte_count == 16'd0) begin
        header_length_next = {in_data[3:0], 2'b00};
      end else if (byte_count == 16'd2) begin
        total_length_next = {in_data, total_length[7:0]};
      end else if (byte_count == 16'd3) begin
        total_length_next = {total_length[15:8], in_data};
      end else if (byte_count >= 16'd12 && byte_count <= 16'd15) begin
        source_register_next = {source_register[23:0], in_data};
      end else if (byte_count >= 16'd16 && byte_count <= 16'd19) begin
        destination_register_next = {destination_register[23:0], in_data};
      end
    end

    in_icmp = in_buf && (byte_count >= {10'b0, header_length_next});
    k = byte_count - {10'b0, header_length_next};
    k_small = (k[15:2] == 14'd0);

    if (in_icmp) begin
      if (k_small) begin
        case (k[1:0])
          2'd0: message_type_next = in_data;
          2'd1: message_code_next = in_data;
          2'd2: begin
            received_checksum_next = {in_data, received_checksum[7:0]};
            v = 8'd0;
          end
          2'd3: begin
            received_checksum_next = {received_checksum[15:8], in_data};
            v = 8'd0;
          end
          default: v = in_data;
        endcase
      end
      if (!k[0]) begin
        pending_high_byte_next = v;
      end else begin
        sum_accumulator_next = add_ones(sum_accumulator, {pending_high_byte, v});
      end
    end

    byte_count_next = (byte_count != 16'hFFFF) ? 16'(byte_count + 16'd1) : byte_count;
    rx_len = (byte_count_next > BUF_BYTES) ? BUF_BYTES : byte_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      header_length <= '0;
      total_length <= '0;
      source_register <= '0;
      destination_register <= '0;
      sum_accumulator <= '0;
      pending_high_byte <= '0;
      message_type <= '0;
      message_code <= '0;
      received_checksum <= '0;
    end else if (take) begin
      if (in_end) begin
        byte_count <= '0;
        header_length <= '0;
        total_length <= '0;
        source_register <= '0;
        destination_register <= '0;
        sum_accumulator <= '0;
        pending_high_byte <= '0;
        message_type <= '0;
        message_code <= '0;
        received_checksum <= '0;
      end else begin
        byte_count <= byte_count_next;
        header_length <= header_length_next;
        total_length <= total_length_next;
        source_register <= source_register_next;
        destination_register <= destination_register_next;
        sum_accumulator <= sum_accumulator_next;
        pending_high_byte <= pending_high_byte_next;
        message_type <= message_type_next;
        message_code <= message_code_next;
        received_checksum <= received_checksum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (take && in_end) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_end) begin
      snap.rx_len <= rx_len;
      snap.total_length <= total_length_next;
      snap.sum <= sum_accumulator_next;
      snap.pending <= pending_high_byte_next;
      snap.pad <= (rx_len > {10'b0, header_length_next}) && rx_len[0];
      snap.message_type <= message_type_next;
      snap.message_code <= message_code_next;
      snap.received_checksum <= received_checksum_next;
      snap.destination <= destination_register_next;
      snap.source <= source_register_next;
    end
  end

endmodule

### hw/rtl/irdp_rx_judge.sv
// Verdict decision on a finished packet and the result register.
module irdp_rx_judge
  import irdp_rx_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = 1500
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        snap_valid,
  output logic        snap_ready,
  input  snap_t       snap,
  input  logic        interface_enabled,
  input  logic        broadcast_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output verdict_t    out_verdict,
  output logic [31:0] out_source
);

  localparam logic [15:0] LONG_LIMIT = 16'(RX_BUFFER_BYTES - LINK_AND_IP_SLACK);

  logic [15:0] sum_final;
  logic        dest_ok;
  verdict_t    verdict;

  always_comb begin
    sum_final = snap.pad ? add_ones(snap.sum, {snap.pending, 8'd0}) : snap.sum;
    dest_ok = ((snap.destination == ADDR_BROADCAST) && broadcast_mode) ||
              ((snap.destination == ADDR_ALL_ROUTERS) && !broadcast_mode);
    if (!interface_enabled) begin
      verdict = VERDICT_DISABLED;
    end else if (snap.rx_len != snap.total_length) begin
      verdict = VERDICT_LEN_MISMATCH;
    end else if (snap.total_length < MIN_ICMP_BYTES) begin
      verdict = VERDICT_SHORT;
    end else if (snap.total_length > LONG_LIMIT) begin
      verdict = VERDICT_LONG;
    end else if (~sum_final != snap.received_checksum) begin
      verdict = VERDICT_CHECKSUM;
    end else if (snap.message_type != TYPE_ADVERT && snap.message_type != TYPE_SOLICIT) begin
      verdict = VERDICT_NOT_IRDP;
    end else if (snap.message_code != 8'd0) begin
      verdict = VERDICT_CODE;
    end else if (!dest_ok) begin
      verdict = VERDICT_DEST;
    end else if (snap.message_type == TYPE_ADVERT) begin
      verdict = VERDICT_ADVERT;
    end else begin
      verdict = VERDICT_SOLICIT;
    end
  end

  assign snap_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      out_verdict <= verdict;
      out_source <= snap.source;
    end
  end

endmodule

### hw/rtl/irdp_receive_packet_check.sv
// Top level of the IRDP receive packet check: stream ports, config registers.
// Last byte to m_axis: input register, snapshot register, result register, in that order.
// Throughput (no m_axis stall): one byte/cycle, at most one verdict/cycle (one-byte packets).
// Stages: input register, header capture and 16-bit end-around-carry sum into a
// packet snapshot register, verdict logic, result register.
// Reset (rst, synchronous): clears both config registers, the per-packet state and all valids.
module irdp_receive_packet_check
  import irdp_rx_pkg::*;
#(
  parameter int RX_BUFFER_BYTES = 1500
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] verdict, [35:4] source_address, [39:36] zero
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [0:0]  cfg_data
);

  logic        interface_enabled;
  logic        broadcast_mode;
  logic        snap_valid;
  logic        snap_ready;
  snap_t       snap;
  verdict_t    out_verdict;
  logic [31:0] out_source;

  always_ff @(posedge clk) begin
    if (rst) begin
      interface_enabled <= 1'b0;
      broadcast_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERFACE_ENABLED: interface_enabled <= cfg_data[0];
        CFG_BROADCAST_MODE:    broadcast_mode <= cfg_data[0];
        default:               interface_enabled <= interface_enabled;
      endcase
    end
  end

  irdp_rx_parse #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  irdp_rx_judge #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
  ) u_judge (
    .clk               (clk),
    .rst               (rst),
    .snap_valid        (snap_valid),
    .snap_ready        (snap_ready),
    .snap              (snap),
    .interface_enabled (interface_enabled),
    .broadcast_mode    (broadcast_mode),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_verdict       (out_verdict),
    .out_source        (out_source)
  );

  assign m_axis_tdata = {4'b0000, out_source, 4'(out_verdict)};

endmodule

### hw/rtl/irdp_rx_checker.sv
// Port-level assertions for the IRDP receive packet check, bound to the top level.
module irdp_rx_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd9)
    else $error("verdict code out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:36] == 4'd0)
    else $error("tdata fill bits not zero");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind irdp_receive_packet_check irdp_rx_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/testbench.sv
// Self-checking testbench for the IRDP receive packet check: byte-stream packets in, verdicts out.
module testbench
  import irdp_rx_pkg::*;
;

  localparam int BUFFER_BYTES = 1500;
  localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;

  typedef struct {
    verdict_t    verdict;
    logic [31:0] source;
  } packet_verdict_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;           // [3:0] verdict, [35:4] source_address, [39:36] zero
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = CFG_INTERFACE_ENABLED;
  logic [0:0]  cfg_data = 1'b0;

  irdp_receive_packet_check #(.RX_BUFFER_BYTES(BUFFER_BYTES)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic        cfg_enabled = 1'b0;
  logic        cfg_broadcast = 1'b0;
  logic [15:0] rx_count = '0;
  logic [5:0]  ihl_bytes = '0;
  logic [15:0] ip_total_len = '0;
  logic [31:0] ip_src = '0;
  logic [31:0] ip_dst = '0;
  logic [15:0] icmp_sum = '0;
  logic [7:0]  icmp_hi = '0;
  logic [7:0]  icmp_type = '0;
  logic [7:0]  icmp_code = '0;
  logic [15:0] icmp_cksum = '0;

  packet_verdict_t expected_verdicts[$];
  int mismatch_count = 0;
  int sent_bytes = 0;
  int verdict_count = 0;
  bit quiet_sender = 1'b0;
  bit quiet_receiver = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  task automatic classify_byte(input logic [7:0] b, input logic l, output bit done,
                               output packet_verdict_t r);
    int off;
    int k;
    int len;
    logic [7:0] lo;
    logic [15:0] s;
    off = rx_count;
    done = 1'b0;
    r.verdict = VERDICT_DISABLED;
    r.source = '0;
    if (off < BUFFER_BYTES) begin
      if (off == 0) ihl_bytes = {b[3:0], 2'b00};
      else if (off == 2) ip_total_len[15:8] = b;
      else if (off == 3) ip_total_len[7:0] = b;
      else if (off >= 12 && off <= 15) ip_src = {ip_src[23:0], b};
      else if (off >= 16 && off <= 19) ip_dst = {ip_dst[23:0], b};
      if (off >= ihl_bytes) begin
        k = off - ihl_bytes;
        lo = b;
        if (k == 0) icmp_type = b;
        else if (k == 1) icmp_code = b;
        else if (k == 2) begin
          icmp_cksum[15:8] = b;
          lo = 8'h00;
        end else if (k == 3) begin
          icmp_cksum[7:0] = b;
          lo = 8'h00;
        end
        if (k % 2 == 0) icmp_hi = lo;
        else icmp_sum = ones_add(icmp_sum, {icmp_hi, lo});
      end
    end
    if (rx_count != 16'hFFFF) rx_count++;
    if (l) begin
      len = (rx_count > BUFFER_BYTES) ? BUFFER_BYTES : rx_count;
      s = icmp_sum;
      if (len > ihl_bytes && (len - ihl_bytes) % 2 == 1) s = ones_add(s, {icmp_hi, 8'h00});
      if (!cfg_enabled) r.verdict = VERDICT_DISABLED;
      else if (len != ip_total_len) r.verdict = VERDICT_LEN_MISMATCH;
      else if (ip_total_len < MIN_ICMP_BYTES) r.verdict = VERDICT_SHORT;
      else if (ip_total_len > BUFFER_BYTES - LINK_AND_IP_SLACK) r.verdict = VERDICT_LONG;
      else if (16'(~s) != icmp_cksum) r.verdict = VERDICT_CHECKSUM;
      else if (icmp_type != TYPE_ADVERT && icmp_type != TYPE_SOLICIT)
        r.verdict = VERDICT_NOT_IRDP;
      else if (icmp_code != 8'h00) r.verdict = VERDICT_CODE;
      else if (!((ip_dst == ADDR_BROADCAST && cfg_broadcast) ||
                 (ip_dst == ADDR_ALL_ROUTERS && !cfg_broadcast)))
        r.verdict = VERDICT_DEST;
      else r.verdict = (icmp_type == TYPE_ADVERT) ? VERDICT_ADVERT : VERDICT_SOLICIT;
      r.source = ip_src;
      done = 1'b1;
      rx_count = '0;
      ihl_bytes = '0;
      ip_total_len = '0;
      ip_src = '0;
      ip_dst = '0;
      icmp_sum = '0;
      icmp_hi = '0;
      icmp_type = '0;
      icmp_code = '0;
      icmp_cksum = '0;
    end
  endtask

  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    packet_verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        log_mismatch($sformatf("unexpected verdict %0d source %h",
                               m_axis_tdata[3:0], m_axis_tdata[35:4]));
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tdata[3:0] !== want.verdict || m_axis_tdata[35:4] !== want.source)
          log_mismatch($sformatf("verdict exp %0d got %0d, source exp %h got %h",
                                 want.verdict, m_axis_tdata[3:0], want.source,
                                 m_axis_tdata[35:4]));
      end
    end
  end

  initial begin : verdict_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = quiet_receiver ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    bit done;
    packet_verdict_t r;
    gap = quiet_sender ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= l;
    do @(posedge clk); while (!s_axis_tready);
    sent_bytes++;
    classify_byte(b, l, done, r);
    if (done) begin
      expected_verdicts.push_back(r);
      verdict_count++;
    end
  endtask

  // Build a packet with IP header fields and an ICMP part at ihl*4, then stream it.
  task automatic stream_packet(input int len, input logic [3:0] ihl, input logic [7:0] kind,
                               input logic [7:0] code, input logic [31:0] dst,
                               input logic [15:0] len_field, input bit bad_sum);
    logic [7:0] pkt[$];
    int i;
    int hdr;
    int icmp_end;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [15:0] sum;
    logic [15:0] cks;
    pkt = {};
    for (i = 0; i < len; i++) pkt.push_back(8'($urandom));
    hdr = ihl * 4;
    pkt[0] = {pkt[0][7:4], ihl};
    if (len > 3) begin
      pkt[2] = len_field[15:8];
      pkt[3] = len_field[7:0];
    end
    if (len > 19) begin
      pkt[16] = dst[31:24];
      pkt[17] = dst[23:16];
      pkt[18] = dst[15:8];
      pkt[19] = dst[7:0];
    end
    if (ihl != 4'd0) begin
      if (hdr < len) pkt[hdr] = kind;
      if (hdr + 1 < len) pkt[hdr + 1] = code;
      if (hdr + 3 < len) begin
        icmp_end = (len > BUFFER_BYTES) ? BUFFER_BYTES : len;
        sum = '0;
        for (i = hdr; i < icmp_end; i += 2) begin
          hi = (i == hdr + 2) ? 8'h00 : pkt[i];
          lo = (i + 1 >= icmp_end || i + 1 == hdr + 3) ? 8'h00 : pkt[i + 1];
          sum = ones_add(sum, {hi, lo});
        end
        cks = ~sum;
        if (bad_sum) cks = cks ^ (16'h0001 << $urandom_range(0, 15));
        pkt[hdr + 2] = cks[15:8];
        pkt[hdr + 3] = cks[7:0];
      end
    end
    for (i = 0; i < len; i++) send_byte(pkt[i], i == len - 1);
  endtask

  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(input logic en, input logic bc);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INTERFACE_ENABLED;
    cfg_data <= en;
    @(posedge clk);
    cfg_index <= CFG_BROADCAST_MODE;
    cfg_data <= bc;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_enabled = en;
    cfg_broadcast = bc;
  endtask

  task automatic test_disabled_interface();
    apply_config(1'b0, 1'b0);
    stream_packet(28, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd28, 1'b0);
    stream_packet(28, 4'd5, TYPE_SOLICIT, 8'h00, ADDR_BROADCAST, 16'd28, 1'b0);
    drain_verdicts();
  endtask

  task automatic test_acceptance();
    apply_config(1'b1, 1'b0);
    stream_packet(36, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd36, 1'b0);
    stream_packet(28, 4'd5, TYPE_SOLICIT, 8'h00, ADDR_ALL_ROUTERS, 16'd28, 1'b0);
    stream_packet(28, 4'd5, TYPE_ADVERT, 8'h00, ADDR_BROADCAST, 16'd28, 1'b0);
    stream_packet(28, 4'd5, TYPE_SOLICIT, 8'h00, $urandom, 16'd28, 1'b0);
    drain_verdicts();
    apply_config(1'b1, 1'b1);
    stream_packet(28, 4'd5, TYPE_ADVERT, 8'h00, ADDR_BROADCAST, 16'd28, 1'b0);
    stream_packet(28, 4'd5, TYPE_SOLICIT, 8'h00, ADDR_BROADCAST, 16'd28, 1'b0);
    stream_packet(28, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd28, 1'b0);
    drain_verdicts();
  endtask

  task automatic test_length_checks();
    apply_config(1'b1, 1'b0);
    stream_packet(28, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd30, 1'b0);
    stream_packet(1, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd1, 1'b0);
    stream_packet(7, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd7, 1'b0);
    stream_packet(8, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd8, 1'b0);
    stream_packet(8, 4'd1, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd8, 1'b0);
    stream_packet(BUFFER_BYTES + 1, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS,
                  16'(BUFFER_BYTES), 1'b0);
    drain_verdicts();
  endtask

  task automatic test_checksum();
    stream_packet(28, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd28, 1'b1);
    stream_packet(29, 4'd5, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd29, 1'b0);
    stream_packet(31, 4'd5, TYPE_SOLICIT, 8'h00, ADDR_ALL_ROUTERS, 16'd31, 1'b1);
    stream_packet(40, 4'd15, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd40, 1'b0);
    drain_verdicts();
  endtask

  task automatic test_type_and_code();
    stream_packet(28, 4'd5, TYPE_ECHO_REQUEST, 8'h00, ADDR_ALL_ROUTERS, 16'd28, 1'b0);
    stream_packet(28, 4'd5, TYPE_SOLICIT, 8'h03, ADDR_ALL_ROUTERS, 16'd28, 1'b0);
    stream_packet(28, 4'd5, TYPE_ADVERT, 8'hFF, ADDR_ALL_ROUTERS, 16'd28, 1'b0);
    drain_verdicts();
  endtask

  task automatic test_header_offsets();
    int ihl;
    for (ihl = 0; ihl < 5; ihl++)
      stream_packet(28, 4'(ihl), TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd28, 1'b0);
    stream_packet(68, 4'd15, TYPE_SOLICIT, 8'h00, ADDR_ALL_ROUTERS, 16'd68, 1'b0);
    stream_packet(32, 4'd6, TYPE_ADVERT, 8'h00, ADDR_ALL_ROUTERS, 16'd32, 1'b0);
    drain_verdicts();
  endtask

  task automatic run_traffic_phase(input logic en, input logic bc);
    int start_bytes;
    int start_verdicts;
    int len;
    int icmp_len;
    int sel;
    logic [3:0] ihl;
    logic [7:0] kind;
    logic [7:0] code;
    logic [31:0] dst;
    logic [15:0] len_field;
    bit bad_sum;
    apply_config(en, bc);
    start_bytes = sent_bytes;
    start_verdicts = verdict_count;
    while (sent_bytes - start_bytes < 40 || verdict_count - start_verdicts < 2) begin
      quiet_sender = ($urandom_range(0, 3) == 0);
      quiet_receiver = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        kind = $urandom_range(0, 1) ? TYPE_ADVERT : TYPE_SOLICIT;
        if ($urandom_range(0, 19) == 0) kind = 8'($urandom);
        icmp_len = (kind == TYPE_ADVERT) ? 8 + 8 * $urandom_range(0, 3) : 8;
        if ($urandom_range(0, 7) == 0) icmp_len += $urandom_range(1, 3);
        code = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        sel = $urandom_range(0, 9);
        if (sel < 8) dst = bc ? ADDR_BROADCAST : ADDR_ALL_ROUTERS;
        else if (sel == 8) dst = bc ? ADDR_ALL_ROUTERS : ADDR_BROADCAST;
        else dst = $urandom;
        len = ihl * 4 + icmp_len;
        len_field = 16'(len);
        if ($urandom_range(0, 14) == 0) len_field = len_field ^ (16'h0001 << $urandom_range(0, 10));
        bad_sum = ($urandom_range(0, 9) == 0);
      end else begin
        len = $urandom_range(1, 64);
        ihl = 4'($urandom_range(0, 15));
        kind = 8'($urandom);
        code = 8'($urandom);
        dst = $urandom;
        len_field = $urandom_range(0, 1) ? 16'(len) : 16'($urandom_range(0, 65535));
        bad_sum = 1'($urandom_range(0, 1));
      end
      stream_packet(len, ihl, kind, code, dst, len_field, bad_sum);
      if ($urandom_range(0, 14) == 0) drain_verdicts();
    end
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
    drain_verdicts();
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(1'b1, 1'b0);
    run_traffic_phase(1'b1, 1'b1);
    run_traffic_phase(1'b0, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_disabled_interface();
    test_acceptance();
    test_length_checks();
    test_checksum();
    test_type_and_code();
    test_header_offsets();
    test_random_traffic();
    drain_verdicts();
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/irdp_rx_pkg.sv
hw/rtl/irdp_rx_parse.sv
hw/rtl/irdp_rx_judge.sv
hw/rtl/irdp_receive_packet_check.sv
hw/rtl/irdp_rx_checker.sv
dv/testbench.sv
